// ===== src/tkp_pkg.sv =====
// ----------------------------------------------------------------------------
// tkp_pkg
// Shared constants, register codes and controller/datapath handshake types
// for the touch key press detector.
// ----------------------------------------------------------------------------
package tkp_pkg;

    localparam int TKP_CHANNELS   = 6;
    localparam int TKP_WINDOW_LEN = 6;

    localparam int SAMPLE_W    = 9;
    localparam int VALUE_W     = 10;
    localparam int CHANNEL_W   = 3;
    localparam int MEAN_W      = 10;
    localparam int WEIGHT_W    = 17;
    localparam int AVG_W       = 26;
    localparam int THRESH_W    = 26;
    localparam int QUIET_W     = 10;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 26;

    localparam int Q16_SHIFT = 16;
    localparam int PROD_W    = AVG_W + WEIGHT_W;
    localparam int P2_W      = MEAN_W + WEIGHT_W;
    localparam int ACC_W     = PROD_W + 1;

    localparam logic [WEIGHT_W-1:0] Q16_ONE    = WEIGHT_W'(65536);
    localparam logic [ACC_W-1:0]    ROUND_HALF = ACC_W'(32768);

    localparam logic [WEIGHT_W-1:0] SLOW_WEIGHT_RESET     = WEIGHT_W'(1966);
    localparam logic [WEIGHT_W-1:0] FAST_WEIGHT_RESET     = WEIGHT_W'(19661);
    localparam logic [THRESH_W-1:0] PRESS_THRESHOLD_RESET = THRESH_W'(170394);
    localparam logic [QUIET_W-1:0]  QUIET_RELEASES_RESET  = QUIET_W'(500);

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SLOW_WEIGHT     = 3'd0,
        CFG_FAST_WEIGHT     = 3'd1,
        CFG_PRESS_THRESHOLD = 3'd2,
        CFG_QUIET_RELEASES  = 3'd3
    } t_cfg_index;

    typedef struct packed {
        logic accept;
        logic write;
        logic rd_issue;
        logic trim;
        logic div_mul;
        logic div_fix;
        logic ema_mul;
        logic ema_add;
        logic ema_fast;
        logic decide;
    } t_dp_cmd;

    typedef struct packed {
        logic is_store;
        logic last_read;
        logic out_free;
    } t_dp_status;

endpackage

// ===== src/tkp_if.sv =====
// ----------------------------------------------------------------------------
// tkp_if
// Valid/ready channels of the touch key press detector: sample input,
// result output and register write port.
// ----------------------------------------------------------------------------
interface tkp_sample_if;
    import tkp_pkg::*;

    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface tkp_result_if;
    import tkp_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CHANNEL_W-1:0] channel;
    logic                 pressed;
    logic                 tone_allowed;
    logic [MEAN_W-1:0]    trimmed_mean;

    modport source (output valid, output channel, output pressed, output tone_allowed,
                    output trimmed_mean, input ready);
    modport sink   (input valid, input channel, input pressed, input tone_allowed,
                    input trimmed_mean, output ready);
endinterface

interface tkp_cfg_if;
    import tkp_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/tkp_ctrl.sv =====
// ----------------------------------------------------------------------------
// tkp_ctrl
// Sequencer for one scan slot: sample store only, or window write, scan,
// trim, divide, slow and fast average updates and the press decision.
// ----------------------------------------------------------------------------
module tkp_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  tkp_pkg::t_dp_status i_status,
    output tkp_pkg::t_dp_cmd    o_cmd
);
    import tkp_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE     = 12'b0000_0000_0001,
        S_WRITE    = 12'b0000_0000_0010,
        S_READ     = 12'b0000_0000_0100,
        S_DRAIN    = 12'b0000_0000_1000,
        S_TRIM     = 12'b0000_0001_0000,
        S_DIV_MUL  = 12'b0000_0010_0000,
        S_DIV_FIX  = 12'b0000_0100_0000,
        S_SLOW_MUL = 12'b0000_1000_0000,
        S_SLOW_ADD = 12'b0001_0000_0000,
        S_FAST_MUL = 12'b0010_0000_0000,
        S_FAST_ADD = 12'b0100_0000_0000,
        S_DECIDE   = 12'b1000_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                // take no transaction while reset is held
                o_in_ready = i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    o_cmd.accept = 1'b1;
                    // second-half slots only store the sample
                    if (!i_status.is_store) begin
                        n_state = S_WRITE;
                    end
                end
            end
            S_WRITE: begin
                o_cmd.write = 1'b1;
                n_state     = S_READ;
            end
            S_READ: begin
                o_cmd.rd_issue = 1'b1;
                if (i_status.last_read) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_TRIM;
            end
            S_TRIM: begin
                o_cmd.trim = 1'b1;
                n_state    = S_DIV_MUL;
            end
            S_DIV_MUL: begin
                o_cmd.div_mul = 1'b1;
                n_state       = S_DIV_FIX;
            end
            S_DIV_FIX: begin
                o_cmd.div_fix = 1'b1;
                n_state       = S_SLOW_MUL;
            end
            S_SLOW_MUL: begin
                o_cmd.ema_mul = 1'b1;
                n_state       = S_SLOW_ADD;
            end
            S_SLOW_ADD: begin
                o_cmd.ema_add = 1'b1;
                n_state       = S_FAST_MUL;
            end
            S_FAST_MUL: begin
                o_cmd.ema_mul  = 1'b1;
                o_cmd.ema_fast = 1'b1;
                n_state        = S_FAST_ADD;
            end
            S_FAST_ADD: begin
                o_cmd.ema_add  = 1'b1;
                o_cmd.ema_fast = 1'b1;
                n_state        = S_DECIDE;
            end
            S_DECIDE: begin
                // hold until the result register can take the transaction
                if (i_status.out_free) begin
                    o_cmd.decide = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== src/tkp_datapath.sv =====
// ----------------------------------------------------------------------------
// tkp_datapath
// Window memory, per-channel averages, trimmed mean divider, shared Q16
// average update unit, configuration registers and result register.
// ----------------------------------------------------------------------------
module tkp_datapath #(
    parameter int CHANNELS   = tkp_pkg::TKP_CHANNELS,
    parameter int WINDOW_LEN = tkp_pkg::TKP_WINDOW_LEN
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tkp_pkg::t_dp_cmd              i_cmd,
    output tkp_pkg::t_dp_status           o_status,
    input  logic [tkp_pkg::SAMPLE_W-1:0]  i_sample,
    tkp_cfg_if.sink                       i_cfg,
    tkp_result_if.source                  o_result
);
    import tkp_pkg::*;

    localparam int SLOTS     = 2 * CHANNELS;
    localparam int SLOT_W    = $clog2(SLOTS);
    localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int POS_W     = $clog2(WINDOW_LEN);
    localparam int DEPTH     = CHANNELS * WINDOW_LEN;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int SUM_W     = $clog2(WINDOW_LEN * (2 ** VALUE_W - 1) + 1);
    localparam int DIVISOR   = WINDOW_LEN - 2;
    localparam int RECIP_W   = Q16_SHIFT + 1;
    localparam int DPROD_W   = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((2 ** Q16_SHIFT) / DIVISOR);

    // slot and write bookkeeping
    logic [SLOT_W-1:0]   r_slot;
    logic [CH_W-1:0]     r_ch;
    logic [VALUE_W-1:0]  r_value;
    logic [ADDR_W-1:0]   r_base;
    logic [ADDR_W-1:0]   r_wr_addr;
    logic [POS_W-1:0]    r_pos     [CHANNELS];
    logic [SAMPLE_W-1:0] r_release [CHANNELS];

    // window memory and scan
    logic [VALUE_W-1:0]  mem [DEPTH];
    logic [DEPTH-1:0]    r_valid;
    logic [POS_W-1:0]    r_k;
    logic [VALUE_W-1:0]  r_rd_data;
    logic                r_rd_ok;
    logic                r_rd_pend;
    logic                r_acc_first;
    logic [SUM_W-1:0]    r_sum;
    logic [VALUE_W-1:0]  r_min;
    logic [VALUE_W-1:0]  r_max;

    // divide and average update
    logic [SUM_W-1:0]    r_trim;
    logic [SUM_W-1:0]    r_quot;
    logic [MEAN_W-1:0]   r_mean;
    logic [PROD_W-1:0]   r_p1;
    logic [P2_W-1:0]     r_p2;
    logic [AVG_W-1:0]    r_slow [CHANNELS];
    logic [AVG_W-1:0]    r_fast [CHANNELS];

    // configuration
    logic [WEIGHT_W-1:0] r_slow_w;
    logic [WEIGHT_W-1:0] r_fast_w;
    logic [THRESH_W-1:0] r_thresh;
    logic [QUIET_W-1:0]  r_quiet;

    // result register
    logic                 r_out_valid;
    logic [CHANNEL_W-1:0] r_out_channel;
    logic                 r_out_pressed;
    logic                 r_out_tone;
    logic [MEAN_W-1:0]    r_out_mean;

    logic [CH_W-1:0]     w_ch;
    logic [CH_W-1:0]     w_rel_idx;
    logic [ADDR_W-1:0]   w_base;
    logic [ADDR_W-1:0]   w_rd_addr;
    logic [VALUE_W-1:0]  w_rd_val;
    logic [DPROD_W-1:0]  w_dprod;
    logic [SUM_W-1:0]    w_rem;
    logic [WEIGHT_W-1:0] w_w_raw;
    logic [WEIGHT_W-1:0] w_wt;
    logic [AVG_W-1:0]    w_avg;
    logic [ACC_W-1:0]    w_acc;
    logic [AVG_W-1:0]    w_new_avg;
    logic [AVG_W:0]      w_margin;
    logic                w_pressed;
    logic                w_tone;

    assign w_ch      = CH_W'(r_slot);
    assign w_rel_idx = CH_W'(r_slot - SLOT_W'(CHANNELS));
    assign w_base    = ADDR_W'(w_ch) * ADDR_W'(WINDOW_LEN);
    assign w_rd_addr = r_base + ADDR_W'(r_k);
    assign w_rd_val  = r_rd_ok ? r_rd_data : '0;

    assign w_dprod = DPROD_W'(r_trim) * DPROD_W'(RECIP);
    assign w_rem   = r_trim - SUM_W'(r_quot * SUM_W'(DIVISOR));

    assign w_w_raw   = i_cmd.ema_fast ? r_fast_w : r_slow_w;
    assign w_wt      = (w_w_raw > Q16_ONE) ? Q16_ONE : w_w_raw;
    assign w_avg     = i_cmd.ema_fast ? r_fast[r_ch] : r_slow[r_ch];
    assign w_acc     = ACC_W'(r_p1) + ACC_W'({r_p2, {Q16_SHIFT{1'b0}}}) + ROUND_HALF;
    assign w_new_avg = w_acc[Q16_SHIFT +: AVG_W];

    // negative margin never counts as a press
    assign w_margin  = {1'b0, r_fast[r_ch]} - {1'b0, r_slow[r_ch]};
    assign w_pressed = !w_margin[AVG_W] && (w_margin[AVG_W-1:0] > r_thresh);
    assign w_tone    = w_pressed && (r_quiet == '0);

    assign o_status.is_store  = (r_slot >= SLOT_W'(CHANNELS));
    assign o_status.last_read = (r_k == POS_W'(WINDOW_LEN - 1));
    assign o_status.out_free  = !r_out_valid || o_result.ready;

    // take no register write while reset is held
    assign i_cfg.ready           = i_rst_n;
    assign o_result.valid        = r_out_valid;
    assign o_result.channel      = r_out_channel;
    assign o_result.pressed      = r_out_pressed;
    assign o_result.tone_allowed = r_out_tone;
    assign o_result.trimmed_mean = r_out_mean;

    // control state and per-channel state with reset values
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot      <= '0;
            r_valid     <= '0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
            r_slow_w    <= SLOW_WEIGHT_RESET;
            r_fast_w    <= FAST_WEIGHT_RESET;
            r_thresh    <= PRESS_THRESHOLD_RESET;
            r_quiet     <= QUIET_RELEASES_RESET;
            for (int c = 0; c < CHANNELS; c++) begin
                r_pos[c]     <= '0;
                r_release[c] <= '0;
                r_slow[c]    <= '0;
                r_fast[c]    <= '0;
            end
        end else begin
            r_rd_pend <= i_cmd.rd_issue;

            if (i_cmd.accept) begin
                r_slot <= (r_slot == SLOT_W'(SLOTS - 1)) ? '0 : r_slot + 1'b1;
                if (o_status.is_store) begin
                    r_release[w_rel_idx] <= i_sample;
                end
            end

            if (i_cmd.write) begin
                r_valid[r_wr_addr] <= 1'b1;
                r_pos[r_ch] <= (r_pos[r_ch] == POS_W'(WINDOW_LEN - 1)) ?
                               '0 : r_pos[r_ch] + 1'b1;
            end

            if (i_cmd.ema_add) begin
                if (i_cmd.ema_fast) begin
                    r_fast[r_ch] <= w_new_avg;
                end else begin
                    r_slow[r_ch] <= w_new_avg;
                end
            end

            if (i_cmd.decide) begin
                r_out_valid <= 1'b1;
                if (!w_pressed && (r_quiet != '0)) begin
                    r_quiet <= r_quiet - 1'b1;
                end
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    CFG_SLOW_WEIGHT:     r_slow_w <= i_cfg.data[WEIGHT_W-1:0];
                    CFG_FAST_WEIGHT:     r_fast_w <= i_cfg.data[WEIGHT_W-1:0];
                    CFG_PRESS_THRESHOLD: r_thresh <= i_cfg.data[THRESH_W-1:0];
                    // reload the startup count with the new value
                    CFG_QUIET_RELEASES:  r_quiet  <= i_cfg.data[QUIET_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // window memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.write) begin
            mem[r_wr_addr] <= r_value;
        end
        if (i_cmd.rd_issue) begin
            r_rd_data <= mem[w_rd_addr];
            r_rd_ok   <= r_valid[w_rd_addr];
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && !o_status.is_store) begin
            r_ch      <= w_ch;
            r_value   <= VALUE_W'(i_sample) + VALUE_W'(r_release[w_ch]);
            r_base    <= w_base;
            r_wr_addr <= w_base + ADDR_W'(r_pos[w_ch]);
        end

        if (i_cmd.write) begin
            r_k         <= '0;
            r_acc_first <= 1'b1;
        end else if (i_cmd.rd_issue) begin
            r_k <= r_k + 1'b1;
        end

        // accumulate sum, minimum and maximum one entry per cycle
        if (r_rd_pend) begin
            r_acc_first <= 1'b0;
            if (r_acc_first) begin
                r_sum <= SUM_W'(w_rd_val);
                r_min <= w_rd_val;
                r_max <= w_rd_val;
            end else begin
                r_sum <= r_sum + SUM_W'(w_rd_val);
                if (w_rd_val < r_min) begin
                    r_min <= w_rd_val;
                end
                if (w_rd_val > r_max) begin
                    r_max <= w_rd_val;
                end
            end
        end

        if (i_cmd.trim) begin
            r_trim <= r_sum - SUM_W'(r_min) - SUM_W'(r_max);
        end

        // reciprocal estimate is exact or one low; fix it with the remainder
        if (i_cmd.div_mul) begin
            r_quot <= SUM_W'(w_dprod >> Q16_SHIFT);
        end

        if (i_cmd.div_fix) begin
            r_mean <= (w_rem >= SUM_W'(DIVISOR)) ? MEAN_W'(r_quot + 1'b1) : MEAN_W'(r_quot);
        end

        if (i_cmd.ema_mul) begin
            r_p1 <= PROD_W'(w_avg) * PROD_W'(Q16_ONE - w_wt);
            r_p2 <= P2_W'(r_mean) * P2_W'(w_wt);
        end

        if (i_cmd.decide) begin
            r_out_channel <= CHANNEL_W'(r_ch);
            r_out_pressed <= w_pressed;
            r_out_tone    <= w_tone;
            r_out_mean    <= r_mean;
        end
    end

endmodule

// ===== src/touch_key_press_detector_unit.sv =====
// ----------------------------------------------------------------------------
// touch_key_press_detector_unit
// An evaluation slot registers its result at the press decision, which waits
// until the result register is free; a store slot gives no result. A new
// sample is taken only when the last slot is done: a store slot ends on
// acceptance, an evaluation slot after the window scan over the single memory
// read port, the divide and the shared average update multipliers.
// Reset (synchronous, active low) clears windows via per-entry valid bits,
// averages and slot counter, loads register defaults; no clearing pass.
// ----------------------------------------------------------------------------
module touch_key_press_detector_unit #(
    parameter int CHANNELS   = tkp_pkg::TKP_CHANNELS,
    parameter int WINDOW_LEN = tkp_pkg::TKP_WINDOW_LEN
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tkp_sample_if.sink    i_sample,
    tkp_result_if.source  o_result,
    tkp_cfg_if.sink       i_cfg
);
    import tkp_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;
    logic       w_in_ready;

    assign i_sample.ready = w_in_ready;

    tkp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_sample.valid),
        .o_in_ready (w_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    tkp_datapath #(
        .CHANNELS   (CHANNELS),
        .WINDOW_LEN (WINDOW_LEN)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .o_status (w_status),
        .i_sample (i_sample.sample),
        .i_cfg    (i_cfg),
        .o_result (o_result)
    );

endmodule
